[design/cemt_pkg.sv]
`timescale 1ns / 1ps

package cemt_pkg;

	// Table geometry and report limit
	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int MAX_RESULTS       = 16;
	localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

	// Wall-clock limits
	localparam int MINUTE_MAX  = 59;
	localparam int HOUR_MAX    = 23;
	localparam int DAY_MAX     = 31;
	localparam int MONTH_MAX   = 12;
	localparam int WEEKDAY_MAX = 6;

	// Command codes
	localparam logic [1:0] OP_ADD      = 2'd0;
	localparam logic [1:0] OP_ADD_ONCE = 2'd1;
	localparam logic [1:0] OP_REMOVE   = 2'd2;
	localparam logic [1:0] OP_TICK     = 2'd3;

	// Status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DUP      = 2'd1;
	localparam logic [1:0] STAT_FULL     = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [30:0] day_mask;
		logic [11:0] month_mask;
		logic [6:0]  weekday_mask;
		logic [31:0] event_id;
		logic [5:0]  now_minute;
		logic [4:0]  now_hour;
		logic [4:0]  now_day;
		logic [3:0]  now_month;
		logic [2:0]  now_weekday;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        fired;
		logic [31:0] fired_id;
		logic        last;
	} rsp_t;

	// One stored table entry
	typedef struct packed {
		logic        one_shot;
		logic [31:0] id;
		logic [59:0] minute_mask;
		logic [23:0] hour_mask;
		logic [30:0] day_mask;
		logic [11:0] month_mask;
		logic [6:0]  weekday_mask;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

endpackage

[design/cron_event_match_table.sv]
`timescale 1ns / 1ps
// Each transaction (add, remove or tick) walks the whole entry memory, one slot per cycle
// while no waiting firing holds the scan, through a single registered read port; a tick scan
// ends early at MAX_RESULTS firings. A new transaction is taken once the final result is registered.
// Each firing of a tick is held until the next one is found or the scan ends, so the final
// result carries last; at most MAX_RESULTS per tick.
// Asynchronous active-low reset clears all valid bits and the sequencer; entry memory
// contents are not reset.
module cron_event_match_table #(
	parameter int TABLE_ENTRIES = cemt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  cemt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output cemt_pkg::rsp_t  rsp
);
	import cemt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CTR_W = $clog2(TABLE_ENTRIES + 1);

	state_t state_q, state_d;

	req_t                 cmd_q;
	logic [CTR_W-1:0]     idx_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	entry_t               mem_q [TABLE_ENTRIES];
	entry_t               rd_s1;
	logic                 chk_v_s1;
	logic [IDX_W-1:0]     slot_s1;
	logic                 pend_v_q;
	logic [31:0]          pend_id_q;
	logic [CNT_W-1:0]     count_q;
	logic                 found_q;
	logic                 free_v_q;
	logic [IDX_W-1:0]     free_slot_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	// Sequencer controls
	logic             accept;
	logic             out_busy;
	logic             is_tick;
	logic             is_add;
	logic             is_remove;
	logic             time_ok;
	logic             slot_valid;
	logic             id_hit;
	logic             free_hit;
	logic             fire;
	logic             cap_hit;
	logic             adv;
	logic             issue;
	logic             emit;
	rsp_t             emit_data;
	logic             clr_en;
	logic             set_en;
	logic             scan_step;
	logic [5:0]       min_pos;
	logic [4:0]       day_pos;
	logic [3:0]       mon_pos;
	logic             mask_ok;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_busy  = out_valid_q && rsp_stall;

	assign is_tick   = (cmd_q.opcode == OP_TICK);
	assign is_remove = (cmd_q.opcode == OP_REMOVE);
	assign is_add    = (cmd_q.opcode == OP_ADD) || (cmd_q.opcode == OP_ADD_ONCE);

	// Qualify the wall-clock fields of the tick
	assign time_ok = (cmd_q.now_minute <= 6'(MINUTE_MAX)) && (cmd_q.now_hour <= 5'(HOUR_MAX))
		&& (cmd_q.now_day >= 5'd1) && (cmd_q.now_day <= 5'(DAY_MAX))
		&& (cmd_q.now_month >= 4'd1) && (cmd_q.now_month <= 4'(MONTH_MAX))
		&& (cmd_q.now_weekday <= 3'(WEEKDAY_MAX));

	// Test the entry under check against the tick
	assign min_pos = cmd_q.now_minute;
	assign day_pos = cmd_q.now_day - 5'd1;
	assign mon_pos = cmd_q.now_month - 4'd1;
	assign mask_ok = (|(rd_s1.minute_mask & (60'd1 << min_pos)))
		&& (|(rd_s1.hour_mask & (24'd1 << cmd_q.now_hour)))
		&& (|(rd_s1.day_mask & (31'd1 << day_pos)))
		&& (|(rd_s1.month_mask & (12'd1 << mon_pos)))
		&& (|(rd_s1.weekday_mask & (7'd1 << cmd_q.now_weekday)));

	assign slot_valid = valid_q[slot_s1];
	assign id_hit     = chk_v_s1 && slot_valid && (rd_s1.id == cmd_q.event_id);
	assign free_hit   = chk_v_s1 && !slot_valid;
	assign fire       = is_tick && chk_v_s1 && slot_valid && time_ok && mask_ok;
	assign cap_hit    = fire && (count_q == CNT_W'(MAX_RESULTS - 1));

	// Next state, result issue and table updates
	always_comb begin
		state_d   = state_q;
		adv       = 1'b0;
		issue     = 1'b0;
		emit      = 1'b0;
		emit_data = '0;
		clr_en    = 1'b0;
		set_en    = 1'b0;
		scan_step = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				// hold the scan while an earlier firing waits for the output register
				adv = !(fire && pend_v_q && out_busy);
				if (adv) begin
					scan_step = 1'b1;
					issue     = (idx_q != CTR_W'(TABLE_ENTRIES)) && !cap_hit;
					if (fire && pend_v_q) begin
						emit      = 1'b1;
						emit_data = '{status: STAT_OK, fired: 1'b1, fired_id: pend_id_q,
							last: 1'b0};
					end
					if (fire) begin
						clr_en = rd_s1.one_shot;
					end
					if (is_remove && id_hit && !found_q) begin
						clr_en = 1'b1;
					end
					if (cap_hit || (idx_q == CTR_W'(TABLE_ENTRIES) && !chk_v_s1)) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (!out_busy) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (is_tick) begin
						if (pend_v_q) begin
							emit_data = '{status: STAT_OK, fired: 1'b1, fired_id: pend_id_q,
								last: 1'b1};
						end else begin
							emit_data = '{status: STAT_OK, fired: 1'b0, fired_id: 32'd0,
								last: 1'b1};
						end
					end else if (is_remove) begin
						emit_data = '{status: found_q ? STAT_OK : STAT_NOTFOUND, fired: 1'b0,
							fired_id: 32'd0, last: 1'b1};
					end else if (found_q) begin
						emit_data = '{status: STAT_DUP, fired: 1'b0, fired_id: 32'd0,
							last: 1'b1};
					end else if (free_v_q) begin
						set_en    = 1'b1;
						emit_data = '{status: STAT_OK, fired: 1'b0, fired_id: 32'd0,
							last: 1'b1};
					end else begin
						emit_data = '{status: STAT_FULL, fired: 1'b0, fired_id: 32'd0,
							last: 1'b1};
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the command of an accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req;
		end
	end

	// Scan counter, read stage and per-scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			chk_v_s1    <= 1'b0;
			slot_s1     <= '0;
			pend_v_q    <= 1'b0;
			pend_id_q   <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			free_v_q    <= 1'b0;
			free_slot_q <= '0;
		end else if (accept) begin
			idx_q    <= '0;
			chk_v_s1 <= 1'b0;
			pend_v_q <= 1'b0;
			count_q  <= '0;
			found_q  <= 1'b0;
			free_v_q <= 1'b0;
		end else if (scan_step) begin
			chk_v_s1 <= issue;
			if (issue) begin
				slot_s1 <= idx_q[IDX_W-1:0];
				idx_q   <= idx_q + CTR_W'(1);
			end
			if (fire) begin
				pend_v_q  <= 1'b1;
				pend_id_q <= rd_s1.id;
				count_q   <= count_q + CNT_W'(1);
			end
			if ((is_add || is_remove) && id_hit) begin
				found_q <= 1'b1;
			end
			if (is_add && free_hit && !free_v_q) begin
				free_v_q    <= 1'b1;
				free_slot_q <= slot_s1;
			end
		end
	end

	// Entry memory: one registered read per scan cycle, one write on a successful add
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= mem_q[idx_q[IDX_W-1:0]];
		end
		if (set_en) begin
			mem_q[free_slot_q] <= '{one_shot: (cmd_q.opcode == OP_ADD_ONCE),
				id: cmd_q.event_id, minute_mask: cmd_q.minute_mask,
				hour_mask: cmd_q.hour_mask, day_mask: cmd_q.day_mask,
				month_mask: cmd_q.month_mask, weekday_mask: cmd_q.weekday_mask};
		end
	end

	// Valid bits: drop on remove or one-shot firing, set on add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_en) begin
			valid_q[slot_s1] <= 1'b0;
		end else if (set_en) begin
			valid_q[free_slot_q] <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= emit_data;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[design/cemt_checker.sv]
`timescale 1ns / 1ps
module cemt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_stall,
	input cemt_pkg::req_t  req,
	input logic            rsp_valid,
	input logic            rsp_stall,
	input cemt_pkg::rsp_t  rsp
);
	import cemt_pkg::*;

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// Go busy once a transaction is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side not stalled after accept");

	// Take a new transaction only behind a final result
	a_accept_behind_last: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && rsp_valid |-> rsp.last)
		else $error("transaction accepted while a non-final result waits");

	// Issue intermediate results only while busy
	a_mid_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall && rsp.fired && rsp.status == STAT_OK)
		else $error("intermediate result outside a tick scan");

endmodule

bind cron_event_match_table cemt_checker u_cemt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

[dv/tb_cron_event_match_table.sv]
`timescale 1ns / 1ps

module tb_cron_event_match_table;
	import cemt_pkg::*;

	localparam int ENTRIES      = TABLE_ENTRIES_DEF;
	localparam int RANDOM_ITEMS = 370;
	localparam int QUIET_TAIL   = 60;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 120;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int ID_POOL      = 24;

	typedef logic [31:0] id_list_t[$];

	// Schedule table mirror: predicts status and firings, then checks results in order
	class cron_table_scoreboard;
		bit     held[ENTRIES];
		entry_t slot[ENTRIES];
		rsp_t   pending_q[$];
		int     mismatches;
		int     n_checked;
		int     n_adds;
		int     n_removes;
		int     n_ticks;
		int     n_fired;
		int     n_dup;
		int     n_full;
		int     n_missing;

		function int find_slot(logic [31:0] id);
			for (int k = 0; k < ENTRIES; k++)
				if (held[k] && slot[k].id == id)
					return k;
			return -1;
		endfunction

		function int held_count();
			int n;
			n = 0;
			for (int k = 0; k < ENTRIES; k++)
				n += int'(held[k]);
			return n;
		endfunction

		function id_list_t held_ids();
			id_list_t ids;
			for (int k = 0; k < ENTRIES; k++)
				if (held[k])
					ids.push_back(slot[k].id);
			return ids;
		endfunction

		function void push(logic [1:0] st, logic f, logic [31:0] id, logic l);
			rsp_t e;
			e.status   = st;
			e.fired    = f;
			e.fired_id = id;
			e.last     = l;
			pending_q.push_back(e);
		endfunction

		// Work out the results of one accepted transaction and advance the table
		function void note_request(req_t r);
			int       hit;
			int       free_slot;
			logic     legal;
			id_list_t fire_ids;
			case (r.opcode)
				OP_ADD, OP_ADD_ONCE: begin
					n_adds++;
					hit = find_slot(r.event_id);
					free_slot = -1;
					for (int k = ENTRIES - 1; k >= 0; k--)
						if (!held[k])
							free_slot = k;
					if (hit >= 0) begin
						n_dup++;
						push(STAT_DUP, 1'b0, '0, 1'b1);
					end else if (free_slot < 0) begin
						n_full++;
						push(STAT_FULL, 1'b0, '0, 1'b1);
					end else begin
						held[free_slot]              = 1'b1;
						slot[free_slot].one_shot     = (r.opcode == OP_ADD_ONCE);
						slot[free_slot].id           = r.event_id;
						slot[free_slot].minute_mask  = r.minute_mask;
						slot[free_slot].hour_mask    = r.hour_mask;
						slot[free_slot].day_mask     = r.day_mask;
						slot[free_slot].month_mask   = r.month_mask;
						slot[free_slot].weekday_mask = r.weekday_mask;
						push(STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				OP_REMOVE: begin
					n_removes++;
					hit = find_slot(r.event_id);
					if (hit < 0) begin
						n_missing++;
						push(STAT_NOTFOUND, 1'b0, '0, 1'b1);
					end else begin
						held[hit] = 1'b0;
						push(STAT_OK, 1'b0, '0, 1'b1);
					end
				end
				default: begin
					n_ticks++;
					// an out-of-range clock field matches no entry
					legal = r.now_minute <= MINUTE_MAX && r.now_hour <= HOUR_MAX &&
						r.now_day >= 1 && r.now_day <= DAY_MAX &&
						r.now_month >= 1 && r.now_month <= MONTH_MAX &&
						r.now_weekday <= WEEKDAY_MAX;
					if (legal) begin
						for (int k = 0; k < ENTRIES && fire_ids.size() < MAX_RESULTS; k++) begin
							if (held[k] && slot[k].minute_mask[r.now_minute] &&
								slot[k].hour_mask[r.now_hour] &&
								slot[k].day_mask[r.now_day - 1] &&
								slot[k].month_mask[r.now_month - 1] &&
								slot[k].weekday_mask[r.now_weekday]) begin
								fire_ids.push_back(slot[k].id);
								// drop one-shot entries once they have fired
								if (slot[k].one_shot)
									held[k] = 1'b0;
							end
						end
					end
					n_fired += fire_ids.size();
					if (fire_ids.size() == 0)
						push(STAT_OK, 1'b0, '0, 1'b1);
					foreach (fire_ids[i])
						push(STAT_OK, 1'b1, fire_ids[i], i == fire_ids.size() - 1);
				end
			endcase
		endfunction

		// Compare one accepted result with the oldest outstanding prediction
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d fired %0b id %h last %0b",
						got.status, got.fired, got.fired_id, got.last);
				return;
			end
			want = pending_q.pop_front();
			n_checked++;
			if (got.status !== want.status || got.fired !== want.fired ||
				got.fired_id !== want.fired_id || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: want %0d %0b %h %0b, got %0d %0b %h %0b",
						$realtime, want.status, want.fired, want.fired_id, want.last,
						got.status, got.fired, got.fired_id, got.last);
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	cron_table_scoreboard sb;
	logic [31:0]          id_pool[ID_POOL];
	int                   n_sent;
	int                   cycles;
	bit                   idle_en;
	bit                   long_hold_done;

	cron_event_match_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				sb.pending_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: check accepted results, stall in bursts, hold off once for long
	initial begin : rsp_side
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				sb.check_response(rsp);
			if (burst > 0)
				burst--;
			else if (!long_hold_done && n_sent >= HOLD_AFTER) begin
				burst = LONG_HOLD;
				long_hold_done = 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0)
				burst = $urandom_range(1, 19);
			rsp_stall <= (burst > 0);
		end
	end

	function automatic logic [63:0] pick_mask();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return '1;
			4, 5, 6, 7: return {$urandom, $urandom};
			8:          return '0;
			default:    return 64'd1 << $urandom_range(0, 63);
		endcase
	endfunction

	function automatic logic [31:0] pick_id();
		if ($urandom_range(0, 99) < 85)
			return id_pool[$urandom_range(0, ID_POOL - 1)];
		return $urandom;
	endfunction

	// Every field random at full width, then the command fields set
	function automatic req_t command(logic [1:0] op, logic [31:0] id);
		req_t r;
		r.opcode       = op;
		r.minute_mask  = 60'(pick_mask());
		r.hour_mask    = 24'(pick_mask());
		r.day_mask     = 31'(pick_mask());
		r.month_mask   = 12'(pick_mask());
		r.weekday_mask = 7'(pick_mask());
		r.event_id     = id;
		r.now_minute   = 6'($urandom);
		r.now_hour     = 5'($urandom);
		r.now_day      = 5'($urandom);
		r.now_month    = 4'($urandom);
		r.now_weekday  = 3'($urandom);
		return r;
	endfunction

	function automatic req_t tick_at(int mn, int hr, int dy, int mo, int wd);
		req_t r;
		r             = command(OP_TICK, $urandom);
		r.now_minute  = 6'(mn);
		r.now_hour    = 5'(hr);
		r.now_day     = 5'(dy);
		r.now_month   = 4'(mo);
		r.now_weekday = 3'(wd);
		return r;
	endfunction

	function automatic req_t random_tick();
		if ($urandom_range(0, 99) < 85)
			return tick_at($urandom_range(0, MINUTE_MAX), $urandom_range(0, HOUR_MAX),
				$urandom_range(1, DAY_MAX), $urandom_range(1, MONTH_MAX),
				$urandom_range(0, WEEKDAY_MAX));
		return command(OP_TICK, $urandom);
	endfunction

	function automatic req_t random_item();
		int u;
		u = $urandom_range(0, 99);
		if (u < 35)
			return command(OP_ADD, pick_id());
		if (u < 50)
			return command(OP_ADD_ONCE, pick_id());
		if (u < 70)
			return command(OP_REMOVE, pick_id());
		return random_tick();
	endfunction

	function automatic req_t open_add(logic [1:0] op, logic [31:0] id);
		req_t r;
		r              = command(op, id);
		r.minute_mask  = '1;
		r.hour_mask    = '1;
		r.day_mask     = '1;
		r.month_mask   = '1;
		r.weekday_mask = '1;
		return r;
	endfunction

	// Offer one transaction and hold it until accepted, then maybe idle
	task automatic send_req(req_t r);
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
		n_sent++;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19))
				@(posedge clk);
		end
	endtask

	initial begin : stimulus
		req_t     r;
		id_list_t ids;
		int       target;
		sb = new();
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < ID_POOL; i++)
			id_pool[i] = $urandom;

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, extremes, duplicates, one-shot removal, bad clock values
		send_req(command(OP_REMOVE, '0));
		send_req(tick_at(0, 0, 1, 1, 0));
		send_req(open_add(OP_ADD, '0));
		send_req(open_add(OP_ADD_ONCE, '1));
		send_req(open_add(OP_ADD, '0));
		r              = command(OP_ADD_ONCE, id_pool[2]);
		r.minute_mask  = 60'd1 << 30;
		r.hour_mask    = 24'd1 << 12;
		r.day_mask     = 31'd1 << 14;
		r.month_mask   = 12'd1 << 5;
		r.weekday_mask = 7'd1 << 3;
		send_req(r);
		send_req(tick_at(MINUTE_MAX, HOUR_MAX, DAY_MAX, MONTH_MAX, WEEKDAY_MAX));
		send_req(tick_at(MINUTE_MAX, HOUR_MAX, DAY_MAX, MONTH_MAX, WEEKDAY_MAX));
		send_req(tick_at(30, 12, 15, 6, 3));
		send_req(tick_at(60, 0, 1, 1, 0));
		send_req(tick_at(63, 0, 1, 1, 0));
		send_req(tick_at(0, 24, 1, 1, 0));
		send_req(tick_at(0, 0, 0, 1, 0));
		send_req(tick_at(0, 0, 1, 0, 0));
		send_req(tick_at(0, 0, 1, 13, 0));
		send_req(tick_at(0, 0, 1, 1, 7));
		send_req(tick_at(0, 0, 1, 1, 0));
		send_req(command(OP_REMOVE, '0));
		send_req(command(OP_REMOVE, '0));
		send_req(command(OP_REMOVE, '1));
		send_req(tick_at(0, 0, 1, 1, 0));

		// Random: mixed batches, table fills with ticks behind them, and drains
		target = n_sent + RANDOM_ITEMS;
		while (n_sent < target) begin
			idle_en = (target - n_sent > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: begin
					repeat (ENTRIES - sb.held_count() + 1) begin
						if ($urandom_range(0, 9) < 7)
							r = open_add($urandom_range(0, 1) ? OP_ADD_ONCE : OP_ADD, $urandom);
						else
							r = command($urandom_range(0, 1) ? OP_ADD_ONCE : OP_ADD, $urandom);
						send_req(r);
					end
					send_req(random_tick());
					send_req(random_tick());
				end
				1: begin
					ids = sb.held_ids();
					foreach (ids[i])
						send_req(command(OP_REMOVE, ids[i]));
					send_req(command(OP_REMOVE, pick_id()));
				end
				default: begin
					repeat ($urandom_range(1, 8))
						send_req(random_item());
				end
			endcase
		end
		idle_en = 1'b0;
		req_valid <= 1'b0;

		// Drain outstanding results, then allow a full scan for strays
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (2 * (ENTRIES + 3))
			@(posedge clk);

		$display("Covered %0d transactions: %0d adds, %0d removes, %0d ticks, %0d results",
			n_sent, sb.n_adds, sb.n_removes, sb.n_ticks, sb.n_checked);
		$display("Saw %0d firings, %0d duplicate ids, %0d full table, %0d unknown ids",
			sb.n_fired, sb.n_dup, sb.n_full, sb.n_missing);
		if (sb.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
